>>> rtl/core/rbd_pkg.sv
// Shared types, constants and helpers for the run-length bitstream decoder.
// No dependencies; imported by every module of the block.
package rbd_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int FIELD_CAP      = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
  localparam int FIELD_W        = 32;
  localparam int CFG_W          = 6;
  localparam int TAKEN_W        = 6;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic REG_COUNT_WIDTH  = 1'b0;
  localparam logic REG_SYMBOL_WIDTH = 1'b1;

  localparam logic [CFG_W-1:0] COUNT_WIDTH_RESET  = CFG_W'(8);
  localparam logic [CFG_W-1:0] SYMBOL_WIDTH_RESET = CFG_W'(8);

  typedef enum logic [2:0] {
    PH_COUNT  = 3'b001,
    PH_LITLEN = 3'b010,
    PH_SYMBOL = 3'b100
  } phase_t;

  typedef struct packed {
    logic in_bit;
    logic final_bit;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_symbol;
    logic [FIELD_W-1:0] run_count;
    logic               last_run;
    logic               truncated;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } push_t;

  function automatic logic [TAKEN_W-1:0] eff_width(input logic [CFG_W-1:0] w);
    logic [TAKEN_W-1:0] e;
    e = TAKEN_W'(w);
    if (e == '0) e = TAKEN_W'(1);
    if (e > TAKEN_W'(FIELD_CAP)) e = TAKEN_W'(FIELD_CAP);
    return e;
  endfunction

endpackage

>>> rtl/core/rbd_field.sv
// Field assembler and decode state: one payload bit per accepted beat.
// Depends on rbd_pkg.
module rbd_field
  import rbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  item_t            item,
  input  logic [CFG_W-1:0] count_width,
  input  logic [CFG_W-1:0] symbol_width,
  output push_t            push
);

  phase_t               phase, phase_next, ph;
  logic [TAKEN_W-1:0]   bits_taken, bits_next, taken_inc, need;
  logic [FIELD_W-1:0]   field_shift, shift_next, shift_inc;
  logic [FIELD_W-1:0]   held_count, held_next;
  logic [FIELD_W-1:0]   literals_left, lit_next;
  logic                 done, emit, clean;
  logic [FIELD_W-1:0]   cnt;

  always_comb begin
    case (phase)
      PH_LITLEN: ph = PH_LITLEN;
      PH_SYMBOL: ph = PH_SYMBOL;
      default:   ph = PH_COUNT;
    endcase

    shift_inc = {field_shift[FIELD_W-2:0], item.in_bit};
    taken_inc = bits_taken + TAKEN_W'(1);
    need      = eff_width((ph == PH_SYMBOL) ? symbol_width : count_width);
    done      = (taken_inc >= need);

    phase_next = ph;
    bits_next  = taken_inc;
    shift_next = shift_inc;
    held_next  = held_count;
    lit_next   = literals_left;
    emit       = 1'b0;
    cnt        = '0;

    if (done) begin
      shift_next = '0;
      bits_next  = '0;
      case (ph)
        PH_LITLEN: begin
          if (shift_inc != '0) begin
            lit_next   = shift_inc;
            held_next  = '0;
            phase_next = PH_SYMBOL;
          end else begin
            phase_next = PH_COUNT;
          end
        end
        PH_SYMBOL: begin
          emit = 1'b1;
          if (literals_left != '0) begin
            cnt      = FIELD_W'(1);
            lit_next = literals_left - FIELD_W'(1);
            if (literals_left == FIELD_W'(1)) phase_next = PH_COUNT;
          end else begin
            cnt        = held_count;
            held_next  = '0;
            phase_next = PH_COUNT;
          end
        end
        default: begin
          if (shift_inc != '0) begin
            held_next  = shift_inc;
            lit_next   = '0;
            phase_next = PH_SYMBOL;
          end else begin
            phase_next = PH_LITLEN;
          end
        end
      endcase
    end

    clean = (phase_next == PH_COUNT) && (bits_next == '0);

    push.valid           = accept && (emit || (item.final_bit && !clean));
    push.data.out_symbol = emit ? shift_inc : '0;
    push.data.run_count  = emit ? cnt : '0;
    push.data.last_run   = item.final_bit;
    push.data.truncated  = item.final_bit && !clean;

    if (item.final_bit) begin
      phase_next = PH_COUNT;
      bits_next  = '0;
      shift_next = '0;
      held_next  = '0;
      lit_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COUNT;
      bits_taken    <= '0;
      field_shift   <= '0;
      held_count    <= '0;
      literals_left <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      bits_taken    <= bits_next;
      field_shift   <= shift_next;
      held_count    <= held_next;
      literals_left <= lit_next;
    end
  end

endmodule

>>> rtl/core/rbd_outq.sv
// Two-entry result register queue between the decoder and the result channel.
// Depends on rbd_pkg.
module rbd_outq
  import rbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  logic [1:0] fill;
  res_t       ent0, ent1;
  logic       pop;

  assign pop       = res_valid && res_ready;
  assign res_valid = (fill != 2'd0);
  assign space     = (fill != 2'd2);
  assign res       = ent0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({push.valid, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push.valid, pop})
      2'b10: begin
        if (fill == 2'd0) ent0 <= push.data;
        else ent1 <= push.data;
      end
      2'b01: begin
        ent0 <= ent1;
      end
      2'b11: begin
        if (fill == 2'd1) begin
          ent0 <= push.data;
        end else begin
          ent0 <= ent1;
          ent1 <= push.data;
        end
      end
      default: begin
        ent0 <= ent0;
      end
    endcase
  end

endmodule

>>> rtl/core/rle_bitstream_decoder.sv
// Top level of the run-length bitstream decoder: register port, decoder, result queue.
// Depends on rbd_pkg, rbd_field and rbd_outq.
//
// The decoder takes one payload bit per cycle while item_ready is high. A result is
// registered into the result queue and reaches the result channel once no earlier
// result still waits ahead of it. Results pass through a two-entry register queue,
// so item_ready drops only while both entries wait to be taken; with res_ready held
// high the block sustains one bit every cycle.
// Field widths come from the count_width (address 0) and symbol_width (address 4)
// registers; write them only while the block is idle.
module rle_bitstream_decoder
  import rbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] count_width, symbol_width;
  logic             accept, space, wr;
  push_t            push;

  assign pready     = 1'b1;
  assign wr         = psel && penable && pwrite;
  assign item_ready = space;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_width  <= COUNT_WIDTH_RESET;
      symbol_width <= SYMBOL_WIDTH_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_COUNT_WIDTH:  count_width  <= pwdata[CFG_W-1:0];
        REG_SYMBOL_WIDTH: symbol_width <= pwdata[CFG_W-1:0];
        default:          count_width  <= count_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COUNT_WIDTH:  prdata = DATA_W'(count_width);
      REG_SYMBOL_WIDTH: prdata = DATA_W'(symbol_width);
      default:          prdata = '0;
    endcase
  end

  rbd_field u_field (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .count_width  (count_width),
    .symbol_width (symbol_width),
    .push         (push)
  );

  rbd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

>>> rtl/core/rbd_checker.sv
// Port-level checks for the run-length bitstream decoder, bound to the top level.
// Depends on rbd_pkg and rle_bitstream_decoder.
module rbd_checker
  import rbd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.truncated |-> res.last_run)
    else $error("truncated beat without last_run");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.truncated |-> res.run_count != '0)
    else $error("complete run with zero count");

  a_trunc_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.run_count == '0 |-> res.truncated && res.out_symbol == '0)
    else $error("zero-count beat carries a symbol");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind rle_bitstream_decoder rbd_checker u_rbd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
